/* rtl/core/nrt_pkg.sv */
// Shared constants, types and helper functions of the note event router.
`timescale 1ns / 1ps

package nrt_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int ACT_W = 5;
  localparam int NW = (CNT_W > ACT_W) ? CNT_W : ACT_W;
  localparam int IDX_W = 16;
  localparam int FREQ_W = 32;
  localparam int VEL_W = 16;
  localparam int CHF_W = 4;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_CHANNELS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WRAP_ENABLE = 1'd1;

  typedef struct packed {
    logic            all_off_pending;
    logic            on_valid;
    logic [CH_W-1:0] on_chan;
    logic            slide_valid;
    logic [CH_W-1:0] slide_chan;
    logic            off_valid;
    logic [CH_W-1:0] off_chan;
  } pulse_state_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [ACT_W-1:0] act);
    logic [NW-1:0] a;
    logic [NW-1:0] r;
    a = NW'(act);
    if (a == NW'(0)) begin
      r = NW'(1);
    end else if (a > NW'(MAX_CHANNELS)) begin
      r = NW'(MAX_CHANNELS);
    end else begin
      r = a;
    end
    return r[CNT_W-1:0];
  endfunction

  function automatic logic [CHF_W-1:0] chan_field(input logic [CH_W-1:0] ch);
    logic [31:0] t;
    t = 32'(ch);
    return t[CHF_W-1:0];
  endfunction

endpackage

/* rtl/core/note_event_router.sv */
// Top level of the note event router: tick sequencer, channel stores and configuration.
// Flow: an accepted tick is applied to the channel stores in the apply state, after the
// sixteen-step serial remainder unit when a note-on is wrapped; the sweep then reads each
// effective channel from the stores and registers it as one result word. A new tick is
// taken only once the sweep of the last one is done; the sweep reads one channel a cycle
// from the stores while the output is not stalled. Reset: asynchronous and active low; it
// clears the store valid bits at once, so every channel reads as zero, and leaves the block ready.
`timescale 1ns / 1ps

module note_event_router (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [nrt_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [nrt_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [nrt_pkg::IDX_W-1:0]    note_index_i,
  input  logic                                note_on_i,
  input  logic                                note_slide_i,
  input  logic                                note_off_i,
  input  logic                                all_off_i,
  input  logic [nrt_pkg::FREQ_W-1:0]          frequency_i,
  input  logic [nrt_pkg::VEL_W-1:0]           velocity_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [nrt_pkg::CHF_W-1:0]           channel_o,
  output logic                                on_pulse_o,
  output logic                                slide_pulse_o,
  output logic                                off_pulse_o,
  output logic [nrt_pkg::FREQ_W-1:0]          held_frequency_o,
  output logic [nrt_pkg::VEL_W-1:0]           held_velocity_o,
  output logic                                last_channel_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_APPLY = 4'b0100,
    S_SWEEP = 4'b1000
  } state_e;

  state_e                              state_q, state_d;
  logic [nrt_pkg::ACT_W-1:0]           act_q, act_d;
  logic                                wrap_q, wrap_d;
  logic [nrt_pkg::IDX_W-1:0]           idx_q;
  logic                                on_q, slide_q, off_q, all_q;
  logic [nrt_pkg::FREQ_W-1:0]          freq_q;
  logic [nrt_pkg::VEL_W-1:0]           vel_q;
  logic                                cur_v_q, cur_v_d;
  logic [nrt_pkg::CH_W-1:0]            cur_q, cur_d;
  nrt_pkg::pulse_state_t               pulses_q, pulses_d;
  logic [nrt_pkg::MAX_CHANNELS-1:0]    fvalid_q, fvalid_d;
  logic [nrt_pkg::MAX_CHANNELS-1:0]    vvalid_q, vvalid_d;

  logic                                accept;
  logic [nrt_pkg::CNT_W-1:0]           count;
  logic [nrt_pkg::IDX_W-1:0]           raw_idx;
  logic [nrt_pkg::IDX_W-1:0]           mag;
  logic                                div_start;
  logic                                div_done;
  logic [nrt_pkg::CH_W-1:0]            rem;
  logic                                idx_ok;
  logic [nrt_pkg::CH_W-1:0]            idx_ch;
  logic                                on_ok, slide_ok, off_ok, cur_in;
  logic                                fwe, vwe;
  logic                                sweep_start;
  logic                                sweep_done;
  logic [nrt_pkg::CH_W-1:0]            raddr;
  logic [nrt_pkg::FREQ_W-1:0]          freq_rdata;
  logic [nrt_pkg::VEL_W-1:0]           vel_rdata;

  assign count = nrt_pkg::eff_count(act_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign raw_idx = note_index_i;
  assign mag = raw_idx[nrt_pkg::IDX_W-1] ? (~raw_idx + nrt_pkg::IDX_W'(1)) : raw_idx;
  assign div_start = accept && note_on_i && wrap_q && !all_off_i;

  always_comb begin
    act_d = act_q;
    wrap_d = wrap_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        nrt_pkg::REG_ACTIVE_CHANNELS: act_d = cfg_wdata_i[nrt_pkg::ACT_W-1:0];
        nrt_pkg::REG_WRAP_ENABLE:     wrap_d = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (wrap_q) begin
      idx_ok = !idx_q[nrt_pkg::IDX_W-1] || (rem == '0);
      idx_ch = rem;
    end else begin
      idx_ok = !idx_q[nrt_pkg::IDX_W-1] && (idx_q < nrt_pkg::IDX_W'(count));
      idx_ch = idx_q[nrt_pkg::CH_W-1:0];
    end
    on_ok = on_q && idx_ok;
    cur_v_d = cur_v_q;
    cur_d = cur_q;
    if (on_q) begin
      cur_v_d = idx_ok;
      cur_d = idx_ch;
    end
    cur_in = cur_v_d && (nrt_pkg::CNT_W'(cur_d) < count);
    slide_ok = slide_q && cur_in;
    off_ok = off_q && cur_in;
    fwe = 1'b0;
    vwe = 1'b0;
    pulses_d = pulses_q;
    fvalid_d = fvalid_q;
    vvalid_d = vvalid_q;
    if (state_q == S_APPLY) begin
      if (all_q) begin
        fvalid_d = '0;
        vvalid_d = '0;
        pulses_d.all_off_pending = 1'b1;
        cur_v_d = cur_v_q;
        cur_d = cur_q;
      end else begin
        fwe = on_ok || slide_ok;
        vwe = on_ok;
        if (fwe) begin
          fvalid_d[cur_d] = 1'b1;
        end
        if (vwe) begin
          vvalid_d[cur_d] = 1'b1;
        end
        pulses_d.all_off_pending = 1'b0;
        pulses_d.on_valid = on_ok;
        pulses_d.on_chan = cur_d;
        pulses_d.slide_valid = slide_ok;
        pulses_d.slide_chan = cur_d;
        pulses_d.off_valid = off_ok;
        pulses_d.off_chan = cur_d;
      end
    end else begin
      cur_v_d = cur_v_q;
      cur_d = cur_q;
    end
  end

  always_comb begin
    state_d = state_q;
    sweep_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = div_start ? S_DIV : S_APPLY;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        sweep_start = 1'b1;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        if (sweep_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q <= nrt_pkg::ACT_RESET;
      wrap_q <= 1'b0;
      cur_v_q <= 1'b0;
      cur_q <= '0;
      pulses_q <= '0;
      fvalid_q <= '0;
      vvalid_q <= '0;
    end else begin
      state_q <= state_d;
      act_q <= act_d;
      wrap_q <= wrap_d;
      cur_v_q <= cur_v_d;
      cur_q <= cur_d;
      pulses_q <= pulses_d;
      fvalid_q <= fvalid_d;
      vvalid_q <= vvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= raw_idx;
      on_q <= note_on_i;
      slide_q <= note_slide_i;
      off_q <= note_off_i;
      all_q <= all_off_i;
      freq_q <= frequency_i;
      vel_q <= velocity_i;
    end
  end

  nrt_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (count),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  nrt_ram #(
    .WIDTH (nrt_pkg::FREQ_W),
    .DEPTH (nrt_pkg::MAX_CHANNELS)
  ) u_freq_ram (
    .clk_i   (clk_i),
    .we_i    (fwe),
    .waddr_i (cur_d),
    .wdata_i (freq_q),
    .raddr_i (raddr),
    .rdata_o (freq_rdata)
  );

  nrt_ram #(
    .WIDTH (nrt_pkg::VEL_W),
    .DEPTH (nrt_pkg::MAX_CHANNELS)
  ) u_vel_ram (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (cur_d),
    .wdata_i (vel_q),
    .raddr_i (raddr),
    .rdata_o (vel_rdata)
  );

  nrt_sweep u_sweep (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (sweep_start),
    .count_i          (count),
    .pulses_i         (pulses_q),
    .freq_valid_i     (fvalid_q),
    .vel_valid_i      (vvalid_q),
    .freq_rdata_i     (freq_rdata),
    .vel_rdata_i      (vel_rdata),
    .raddr_o          (raddr),
    .done_o           (sweep_done),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .channel_o        (channel_o),
    .on_pulse_o       (on_pulse_o),
    .slide_pulse_o    (slide_pulse_o),
    .off_pulse_o      (off_pulse_o),
    .held_frequency_o (held_frequency_o),
    .held_velocity_o  (held_velocity_o),
    .last_channel_o   (last_channel_o)
  );

endmodule

/* rtl/core/nrt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module nrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/nrt_rem_unit.sv */
// Bit-serial remainder unit for wrapping the note-on index by the channel count.
`timescale 1ns / 1ps

module nrt_rem_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [nrt_pkg::IDX_W-1:0]    dividend_i,
  input  logic [nrt_pkg::CNT_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [nrt_pkg::CH_W-1:0]     rem_o
);

  localparam int STEP_W = $clog2(nrt_pkg::IDX_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [STEP_W-1:0]           cnt_q, cnt_d;
  logic [nrt_pkg::IDX_W-1:0]   dvd_q, dvd_d;
  logic [nrt_pkg::CNT_W-1:0]   rem_q, rem_d;
  logic [nrt_pkg::CNT_W:0]     trial;
  logic [nrt_pkg::CNT_W:0]     diff;

  always_comb begin
    trial = {rem_q, dvd_q[nrt_pkg::IDX_W-1]};
    diff = trial - {1'b0, divisor_i};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      rem_d = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[nrt_pkg::IDX_W-2:0], 1'b0};
      rem_d = (trial >= {1'b0, divisor_i}) ? diff[nrt_pkg::CNT_W-1:0]
                                           : trial[nrt_pkg::CNT_W-1:0];
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(nrt_pkg::IDX_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o = rem_q[nrt_pkg::CH_W-1:0];

endmodule

/* rtl/core/nrt_sweep.sv */
// Channel sweep: reads every active channel from the stores and drives the result register.
`timescale 1ns / 1ps

module nrt_sweep (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [nrt_pkg::CNT_W-1:0]         count_i,
  input  nrt_pkg::pulse_state_t             pulses_i,
  input  logic [nrt_pkg::MAX_CHANNELS-1:0]  freq_valid_i,
  input  logic [nrt_pkg::MAX_CHANNELS-1:0]  vel_valid_i,
  input  logic [nrt_pkg::FREQ_W-1:0]        freq_rdata_i,
  input  logic [nrt_pkg::VEL_W-1:0]         vel_rdata_i,
  output logic [nrt_pkg::CH_W-1:0]          raddr_o,
  output logic                              done_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nrt_pkg::CHF_W-1:0]         channel_o,
  output logic                              on_pulse_o,
  output logic                              slide_pulse_o,
  output logic                              off_pulse_o,
  output logic [nrt_pkg::FREQ_W-1:0]        held_frequency_o,
  output logic [nrt_pkg::VEL_W-1:0]         held_velocity_o,
  output logic                              last_channel_o
);

  logic                         act_q, act_d;
  logic [nrt_pkg::CNT_W-1:0]    iss_q, iss_d;
  logic                         pend_q, pend_d;
  logic [nrt_pkg::CH_W-1:0]     pidx_q, pidx_d;
  logic                         fv_q, vv_q;
  logic                         ovalid_q, ovalid_d;
  logic [nrt_pkg::CHF_W-1:0]    och_q;
  logic                         oon_q, osl_q, ooff_q, olast_q;
  logic [nrt_pkg::FREQ_W-1:0]   ofreq_q;
  logic [nrt_pkg::VEL_W-1:0]    ovel_q;
  logic                         load;
  logic                         hold;
  logic                         issue;
  logic [nrt_pkg::CH_W-1:0]     raddr;

  always_comb begin
    load = pend_q && (!ovalid_q || out_ready_i);
    hold = pend_q && !load;
    raddr = hold ? pidx_q : iss_q[nrt_pkg::CH_W-1:0];
    issue = act_q && !hold && (iss_q < count_i);
    done_o = act_q && (iss_q == count_i) && !pend_q;
    act_d = act_q;
    iss_d = iss_q;
    pend_d = pend_q;
    pidx_d = pidx_q;
    if (start_i) begin
      act_d = 1'b1;
      iss_d = '0;
      pend_d = 1'b0;
    end else begin
      if (done_o) begin
        act_d = 1'b0;
      end
      if (issue) begin
        pend_d = 1'b1;
        pidx_d = iss_q[nrt_pkg::CH_W-1:0];
        iss_d = iss_q + nrt_pkg::CNT_W'(1);
      end else if (load) begin
        pend_d = 1'b0;
      end
    end
    if (load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      iss_q <= '0;
      pend_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      act_q <= act_d;
      iss_q <= iss_d;
      pend_q <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    fv_q <= freq_valid_i[raddr];
    vv_q <= vel_valid_i[raddr];
    if (load) begin
      och_q <= nrt_pkg::chan_field(pidx_q);
      oon_q <= !pulses_i.all_off_pending && pulses_i.on_valid
               && (pulses_i.on_chan == pidx_q);
      osl_q <= !pulses_i.all_off_pending && pulses_i.slide_valid
               && (pulses_i.slide_chan == pidx_q);
      ooff_q <= pulses_i.all_off_pending
                || (pulses_i.off_valid && (pulses_i.off_chan == pidx_q));
      ofreq_q <= fv_q ? freq_rdata_i : '0;
      ovel_q <= vv_q ? vel_rdata_i : '0;
      olast_q <= (nrt_pkg::CNT_W'(pidx_q) == (count_i - nrt_pkg::CNT_W'(1)));
    end
  end

  assign raddr_o = raddr;
  assign out_valid_o = ovalid_q;
  assign channel_o = och_q;
  assign on_pulse_o = oon_q;
  assign slide_pulse_o = osl_q;
  assign off_pulse_o = ooff_q;
  assign held_frequency_o = ofreq_q;
  assign held_velocity_o = ovel_q;
  assign last_channel_o = olast_q;

endmodule

/* rtl/core/nrt_checker.sv */
// Port-level checker of the note event router and the bind that attaches it.
`timescale 1ns / 1ps

module nrt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [nrt_pkg::CHF_W-1:0]     channel_o,
  input logic [nrt_pkg::FREQ_W-1:0]    held_frequency_o,
  input logic                          last_channel_o
);

  logic [nrt_pkg::CHF_W-1:0] exp_ch_q;
  logic [1:0]                open_q;
  logic                      in_acc;
  logic                      out_acc;

  assign in_acc = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ch_q <= '0;
      open_q <= '0;
    end else begin
      if (out_acc) begin
        exp_ch_q <= last_channel_o ? '0 : exp_ch_q + nrt_pkg::CHF_W'(1);
      end
      open_q <= open_q + 2'(in_acc) - 2'(out_acc && last_channel_o);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(channel_o)
      && $stable(held_frequency_o))
    else $error("result word changed while stalled");

  a_chan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> channel_o == exp_ch_q)
    else $error("result words out of channel order");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> open_q != 2'd0)
    else $error("result word without an accepted tick");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input taken again before the tick was processed");

endmodule

bind note_event_router nrt_checker u_nrt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .channel_o        (channel_o),
  .held_frequency_o (held_frequency_o),
  .last_channel_o   (last_channel_o)
);

/* test/note_event_router_tb.sv */
// Self-checking testbench for the note event router: directed and random ticks checked per channel.
`timescale 1ns / 1ps

module note_event_router_tb;
  import nrt_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 25;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic signed [IDX_W-1:0] idx;
    logic                    on;
    logic                    slide;
    logic                    off;
    logic                    all_off;
    logic [FREQ_W-1:0]       freq;
    logic [VEL_W-1:0]        vel;
  } note_tick_t;

  typedef struct packed {
    logic [CHF_W-1:0]  channel;
    logic              on_pulse;
    logic              slide_pulse;
    logic              off_pulse;
    logic [FREQ_W-1:0] freq;
    logic [VEL_W-1:0]  vel;
    logic              last;
  } chan_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  note_tick_t drv_tick = '0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  logic in_ready_o;
  logic out_valid_o;
  logic [CHF_W-1:0] channel_o;
  logic on_pulse_o;
  logic slide_pulse_o;
  logic off_pulse_o;
  logic [FREQ_W-1:0] held_frequency_o;
  logic [VEL_W-1:0] held_velocity_o;
  logic last_channel_o;

  note_tick_t tick_q[$];
  chan_report_t chan_report_q[$];
  chan_report_t got_word;
  chan_report_t want_word;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count = 0;
  int ticks_taken = 0;
  int words_checked = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  // Predictor state: configuration, per-channel stores and pulse bookkeeping.
  logic [ACT_W-1:0] cfg_act = ACT_RESET;
  logic cfg_wrap = 1'b0;
  logic on_f[MAX_CHANNELS];
  logic slide_f[MAX_CHANNELS];
  logic off_f[MAX_CHANNELS];
  logic [FREQ_W-1:0] held_freq[MAX_CHANNELS];
  logic [VEL_W-1:0] held_vel[MAX_CHANNELS];
  int cur_ch = -1;
  int due_on = -1;
  int due_slide = -1;
  int due_off = -1;
  logic all_off_due = 1'b0;

  note_event_router uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .note_index_i    (drv_tick.idx),
    .note_on_i       (drv_tick.on),
    .note_slide_i    (drv_tick.slide),
    .note_off_i      (drv_tick.off),
    .all_off_i       (drv_tick.all_off),
    .frequency_i     (drv_tick.freq),
    .velocity_i      (drv_tick.vel),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .channel_o       (channel_o),
    .on_pulse_o      (on_pulse_o),
    .slide_pulse_o   (slide_pulse_o),
    .off_pulse_o     (off_pulse_o),
    .held_frequency_o(held_frequency_o),
    .held_velocity_o (held_velocity_o),
    .last_channel_o  (last_channel_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int bank_size();
    if (cfg_act == '0) begin
      return 1;
    end
    if (int'(cfg_act) > MAX_CHANNELS) begin
      return MAX_CHANNELS;
    end
    return int'(cfg_act);
  endfunction

  function automatic bit in_bank(input int ch, input int n);
    return ch >= 0 && ch < n;
  endfunction

  // Applies one tick to the channel bank and queues the word expected for every channel in use.
  function automatic void route_tick(input note_tick_t t);
    int n;
    int ch;
    int i;
    chan_report_t r;
    n = bank_size();
    if (t.all_off) begin
      for (i = 0; i < MAX_CHANNELS; i++) begin
        on_f[i] = 1'b0;
        slide_f[i] = 1'b0;
        off_f[i] = 1'b1;
        held_freq[i] = '0;
        held_vel[i] = '0;
      end
      all_off_due = 1'b1;
    end else begin
      if (due_on >= 0) on_f[due_on] = 1'b0;
      if (due_slide >= 0) slide_f[due_slide] = 1'b0;
      if (due_off >= 0) off_f[due_off] = 1'b0;
      due_on = -1;
      due_slide = -1;
      due_off = -1;
      if (all_off_due) begin
        for (i = 0; i < MAX_CHANNELS; i++) off_f[i] = 1'b0;
        all_off_due = 1'b0;
      end
      if (t.on) begin
        ch = int'(t.idx);
        if (cfg_wrap) ch = ch % n;
        if (in_bank(ch, n)) begin
          cur_ch = ch;
          due_on = ch;
          on_f[ch] = 1'b1;
          held_freq[ch] = t.freq;
          held_vel[ch] = t.vel;
        end else begin
          cur_ch = -1;
        end
      end
      if (t.slide && in_bank(cur_ch, n)) begin
        due_slide = cur_ch;
        slide_f[cur_ch] = 1'b1;
        held_freq[cur_ch] = t.freq;
      end
      if (t.off && in_bank(cur_ch, n)) begin
        due_off = cur_ch;
        off_f[cur_ch] = 1'b1;
      end
    end
    for (i = 0; i < n; i++) begin
      r.channel = CHF_W'(i);
      r.on_pulse = on_f[i];
      r.slide_pulse = slide_f[i];
      r.off_pulse = off_f[i];
      r.freq = held_freq[i];
      r.vel = held_vel[i];
      r.last = (i == n - 1);
      chan_report_q.push_back(r);
    end
  endfunction

  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  task automatic flag_error(input string what, input chan_report_t want, input chan_report_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: %s: expected ch %0d on %b slide %b off %b freq %h vel %h last %b", $realtime,
               what, want.channel, want.on_pulse, want.slide_pulse, want.off_pulse, want.freq,
               want.vel, want.last);
      $display("    got ch %0d on %b slide %b off %b freq %h vel %h last %b", got.channel,
               got.on_pulse, got.slide_pulse, got.off_pulse, got.freq, got.vel, got.last);
    end
  endtask

  task automatic push_tick(input logic [IDX_W-1:0] idx, input logic on, input logic slide,
                           input logic off, input logic all_off, input logic [FREQ_W-1:0] freq,
                           input logic [VEL_W-1:0] vel);
    note_tick_t t;
    t.idx = idx;
    t.on = on;
    t.slide = slide;
    t.off = off;
    t.all_off = all_off;
    t.freq = freq;
    t.vel = vel;
    tick_q.push_back(t);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (addr == REG_ACTIVE_CHANNELS) begin
      cfg_act = data;
    end else begin
      cfg_wrap = data[0];
    end
  endtask

  task automatic set_bank(input int act, input logic wrap);
    write_reg(REG_ACTIVE_CHANNELS, CFG_DATA_W'(act));
    write_reg(REG_WRAP_ENABLE, {4'($urandom), wrap});
    settings_used++;
    @(negedge clk_i);
  endtask

  task automatic set_pace(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Waits until every tick has gone in and every word has come out, then lets the pipeline drain.
  task automatic settle();
    while (tick_q.size() != 0 || in_valid || chan_report_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Mostly complete notes (on, a few slides with plain ticks between, off), the rest random noise.
  task automatic queue_random_ticks(input int count);
    int made;
    int n;
    int slides;
    int k;
    logic [IDX_W-1:0] idx;
    made = 0;
    n = bank_size();
    while (made < count) begin
      if ($urandom_range(99) < 20) begin
        push_tick(IDX_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  ($urandom_range(7) == 0), pick_freq(), VEL_W'($urandom));
        made++;
      end else begin
        idx = cfg_wrap ? IDX_W'($urandom) : IDX_W'($urandom_range(n - 1));
        push_tick(idx, 1'b1, 1'b0, 1'b0, 1'b0, pick_freq(), VEL_W'($urandom));
        made++;
        slides = $urandom_range(3);
        for (k = 0; k < slides; k++) begin
          if ($urandom_range(1) == 1) begin
            push_tick(IDX_W'($urandom), 1'b0, 1'b0, 1'b0, 1'b0, pick_freq(), VEL_W'($urandom));
            made++;
          end
          push_tick(IDX_W'($urandom), 1'b0, 1'b1, 1'b0, 1'b0, pick_freq(), VEL_W'($urandom));
          made++;
        end
        push_tick(IDX_W'($urandom), 1'b0, 1'b0, 1'b1, 1'b0, pick_freq(), VEL_W'($urandom));
        made++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      on_f[i] = 1'b0;
      slide_f[i] = 1'b0;
      off_f[i] = 1'b0;
      held_freq[i] = '0;
      held_vel[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        route_tick(drv_tick);
        ticks_taken++;
      end
      if (!in_valid || in_ready_o) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_tick <= tick_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        got_word = {channel_o, on_pulse_o, slide_pulse_o, off_pulse_o, held_frequency_o,
                    held_velocity_o, last_channel_o};
        if (chan_report_q.size() == 0) begin
          flag_error("channel word with none expected", '0, got_word);
        end else begin
          want_word = chan_report_q.pop_front();
          if (got_word !== want_word) flag_error("channel word mismatch", want_word, got_word);
          words_checked++;
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed ticks at the reset setting: extremes of index, frequency and velocity, rejected
    // indices, every trigger alone and together, and all-off over other triggers.
    set_pace(24, 49);
    settings_used++;
    push_tick(16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
    push_tick(16'sd0, 1'b1, 1'b0, 1'b0, 1'b0, '1, '1);
    push_tick(16'sd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h1234_5678, 16'h0001);
    push_tick(16'sd0, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 16'h0);
    push_tick(16'sd15, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0);
    push_tick(16'sd16, 1'b1, 1'b0, 1'b0, 1'b0, 32'hDEAD_BEEF, 16'hBEEF);
    push_tick(16'sd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0BAD_F00D, 16'h1111);
    push_tick(16'sd0, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 16'h0);
    push_tick(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 32'h5555_AAAA, 16'hAAAA);
    push_tick(16'h7FFF, 1'b1, 1'b0, 1'b0, 1'b0, 32'hAAAA_5555, 16'h5555);
    push_tick(16'h8000, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0001_0000, 16'h8000);
    push_tick(16'sd7, 1'b1, 1'b1, 1'b1, 1'b0, 32'hA5A5_A5A5, 16'h5A5A);
    push_tick(16'sd3, 1'b1, 1'b1, 1'b1, 1'b1, 32'h1357_9BDF, 16'h2468);
    push_tick(16'sd0, 1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_0000, 16'hFF00);
    push_tick(16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 16'h0);
    push_tick(16'sd12, 1'b1, 1'b0, 1'b0, 1'b0, 32'h00C0_FFEE, 16'h7777);
    settle();

    // Channel twelve stays current while the bank shrinks below it.
    set_bank(4, 1'b0);
    push_tick(16'sd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h1111_2222, 16'h3333);
    push_tick(16'sd0, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 16'h0);
    settle();
    set_bank(16, 1'b0);
    push_tick(16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 16'h0);
    settle();

    // Wrapped note-on: negative remainders are rejected, a zero remainder is kept.
    set_bank(5, 1'b1);
    push_tick(-16'sd7, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0007, 16'h0007);
    push_tick(16'sd12, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_000C, 16'h000C);
    push_tick(-16'sd5, 1'b1, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFB, 16'hFFFB);
    push_tick(16'h7FFF, 1'b1, 1'b0, 1'b0, 1'b0, 32'h7FFF_0000, 16'h7FFF);
    push_tick(16'h8000, 1'b1, 1'b0, 1'b0, 1'b0, 32'h8000_0000, 16'h8000);
    push_tick(16'sd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h4444_4444, 16'h4444);
    settle();

    set_bank(16, 1'b0);
    queue_random_ticks(72);
    settle();

    // The receiver holds off for a long stretch while a full phase of ticks is offered.
    set_bank(7, 1'b1);
    queue_random_ticks(72);
    @(posedge clk_i);
    hold_req <= 1'b1;
    settle();

    set_pace(49, 24);
    set_bank(0, 1'b1);
    queue_random_ticks(72);
    settle();
    set_bank(31, 1'b1);
    queue_random_ticks(72);
    settle();

    set_pace(0, 0);
    set_bank(1, 1'b0);
    queue_random_ticks(72);
    settle();
    set_bank(16, 1'b1);
    queue_random_ticks(72);
    settle();

    if (chan_report_q.size() != 0) err_count++;
    $display("Sent %0d ticks and checked %0d channel words across %0d bank settings,", ticks_taken,
             words_checked, settings_used);
    $display("with wrap on and off, bank sizes 0 to 31, all-off and a long output hold-off.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors found", err_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
